### rtl/ftfp_pkg.sv
// Shared types, constants and codes for the floppy track format parser.
`timescale 1ns / 1ps
`default_nettype none

package ftfp_pkg;

    localparam int SECTOR_BYTES    = 256;
    localparam int SIMPLE_SECTORS  = 10;
    localparam int DIRECTORY_TRACK = 17;

    localparam int DLEFT_W  = $clog2(SECTOR_BYTES + 1);
    localparam int BUDGET_W = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam logic [BUDGET_W-1:0] TRACK_LENGTH_RESET = 14'd3125;

    localparam logic [7:0] MARK_INDEX     = 8'hFC;
    localparam logic [7:0] MARK_ID        = 8'hFE;
    localparam logic [7:0] MARK_DATA      = 8'hF8;
    localparam logic [7:0] MARK_DATA_MASK = 8'hFC;
    localparam logic [1:0] MARK_NORMAL    = 2'b11;
    localparam logic [7:0] CRC_BYTE       = 8'hF7;
    localparam logic [7:0] SIZE_CODE      = 8'h01;

    localparam logic [7:0] FLAG_DENSITY = 8'h80;
    localparam logic [7:0] FLAG_DIR     = 8'h20;
    localparam logic [7:0] FLAG_SIDE    = 8'h10;
    localparam logic [7:0] FLAG_CRC     = 8'h08;

    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TRACK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SIDE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_DENS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIMPLE_IMAGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LENGTH = 3'd4;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_BYTE  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DATA   = 3'd1,
        EV_HEADER = 3'd2,
        EV_DONE   = 3'd3,
        EV_ERROR  = 3'd4
    } t_event;

    typedef enum logic [3:0] {
        ERR_NONE    = 4'd0,
        ERR_TRACK   = 4'd1,
        ERR_HEAD    = 4'd2,
        ERR_SIZE    = 4'd3,
        ERR_SIDED   = 4'd4,
        ERR_DENSITY = 4'd5,
        ERR_SECTOR  = 4'd6,
        ERR_DIR     = 4'd7,
        ERR_CRC     = 4'd8
    } t_error;

    typedef struct packed {
        logic [6:0]          physical_track;
        logic                head_side;
        logic                double_density;
        logic                simple_image;
        logic [BUDGET_W-1:0] track_length;
    } t_cfg;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] store_byte;
        logic [7:0] byte_index;
        logic [7:0] id_track;
        logic [7:0] id_sector;
        logic [7:0] id_flags;
        t_error     error_code;
        logic       busy_res;
    } t_result;

endpackage

`default_nettype wire

### rtl/ftfp_cfg.sv
// Configuration register bank of the track format parser.
`timescale 1ns / 1ps
`default_nettype none

module ftfp_cfg (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_wr,
    input  wire  [ftfp_pkg::CFG_IDX_W-1:0]    i_idx,
    input  wire  [ftfp_pkg::CFG_DATA_W-1:0]   i_data,
    output ftfp_pkg::t_cfg                    o_cfg
);
    import ftfp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.physical_track <= '0;
            r_cfg.head_side      <= 1'b0;
            r_cfg.double_density <= 1'b0;
            r_cfg.simple_image   <= 1'b0;
            r_cfg.track_length   <= TRACK_LENGTH_RESET;
        end else if (i_wr) begin
            case (i_idx)
                CFG_PHYS_TRACK:   r_cfg.physical_track <= i_data[6:0];
                CFG_HEAD_SIDE:    r_cfg.head_side      <= i_data[0];
                CFG_DOUBLE_DENS:  r_cfg.double_density <= i_data[0];
                CFG_SIMPLE_IMAGE: r_cfg.simple_image   <= i_data[0];
                CFG_TRACK_LENGTH: r_cfg.track_length   <= i_data[BUDGET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/ftfp_parser.sv
// Parse state machine: consumes one request per cycle while i_accept is high and forms its result.
`timescale 1ns / 1ps
`default_nettype none

module ftfp_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ftfp_pkg::t_cfg       i_cfg,
    input  wire                  i_accept,
    input  wire                  i_opcode,
    input  wire  [7:0]           i_data_byte,
    output ftfp_pkg::t_result    o_result
);
    import ftfp_pkg::*;

    typedef enum logic [3:0] {
        ST_GAP0    = 4'd0,
        ST_GAP1    = 4'd1,
        ST_TRACKID = 4'd2,
        ST_HEADID  = 4'd3,
        ST_SECID   = 4'd4,
        ST_SIZEID  = 4'd5,
        ST_GAP2    = 4'd6,
        ST_DATA    = 4'd7,
        ST_DCRC    = 4'd8,
        ST_DONE    = 4'd15
    } t_state;

    t_state              r_state, n_state;
    logic [BUDGET_W-1:0] r_raw_left, n_raw_left;
    logic [DLEFT_W-1:0]  r_data_left, n_data_left;
    logic [7:0]          r_hdr_track, n_hdr_track;
    logic [7:0]          r_hdr_sector, n_hdr_sector;
    logic [7:0]          r_hdr_flags, n_hdr_flags;
    t_result             res;
    logic [DLEFT_W-1:0]  idx_full;
    logic [BUDGET_W-1:0] raw_dec;
    logic                fail;
    t_error              fail_code;

    always_comb begin
        n_state      = r_state;
        n_raw_left   = r_raw_left;
        n_data_left  = r_data_left;
        n_hdr_track  = r_hdr_track;
        n_hdr_sector = r_hdr_sector;
        n_hdr_flags  = r_hdr_flags;
        res          = '0;
        res.event_res  = EV_NONE;
        res.error_code = ERR_NONE;
        fail      = 1'b0;
        fail_code = ERR_NONE;
        idx_full  = DLEFT_W'(SECTOR_BYTES) - r_data_left;
        raw_dec   = r_raw_left - BUDGET_W'(1);

        if (i_opcode == OP_START) begin
            n_raw_left  = i_cfg.track_length;
            n_data_left = '0;
            n_state     = ST_GAP0;
        end else if (r_state != ST_DONE) begin
            if (r_raw_left == '0) begin
                n_state       = ST_DONE;
                n_data_left   = '0;
                res.event_res = EV_DONE;
            end else begin
                n_raw_left = raw_dec;
                case (r_state)
                    ST_GAP0: begin
                        if (i_data_byte == MARK_INDEX) begin
                            n_state = ST_GAP1;
                        end else if (i_data_byte == MARK_ID) begin
                            n_state = ST_TRACKID;
                        end
                    end
                    ST_GAP1: begin
                        if (i_data_byte == MARK_ID) begin
                            n_state = ST_TRACKID;
                        end
                    end
                    ST_TRACKID: begin
                        n_hdr_track = i_data_byte;
                        if (i_data_byte != {1'b0, i_cfg.physical_track}) begin
                            fail      = 1'b1;
                            fail_code = ERR_TRACK;
                        end else begin
                            n_state = ST_HEADID;
                        end
                    end
                    ST_HEADID: begin
                        if (i_cfg.simple_image && i_data_byte != 8'd0) begin
                            fail      = 1'b1;
                            fail_code = ERR_SIDED;
                        end else if (i_cfg.simple_image && i_cfg.double_density) begin
                            fail      = 1'b1;
                            fail_code = ERR_DENSITY;
                        end else if (!i_cfg.simple_image
                                     && i_data_byte != {7'd0, i_cfg.head_side}) begin
                            fail      = 1'b1;
                            fail_code = ERR_HEAD;
                        end else begin
                            n_hdr_flags = ((i_data_byte != 8'd0) ? FLAG_SIDE : 8'd0)
                                        | (i_cfg.double_density ? FLAG_DENSITY : 8'd0);
                            n_state = ST_SECID;
                        end
                    end
                    ST_SECID: begin
                        n_hdr_sector = i_data_byte;
                        if (i_cfg.simple_image && i_data_byte >= 8'(SIMPLE_SECTORS)) begin
                            fail      = 1'b1;
                            fail_code = ERR_SECTOR;
                        end else begin
                            n_state = ST_SIZEID;
                        end
                    end
                    ST_SIZEID: begin
                        if (i_data_byte != SIZE_CODE) begin
                            fail      = 1'b1;
                            fail_code = ERR_SIZE;
                        end else begin
                            n_state = ST_GAP2;
                        end
                    end
                    ST_GAP2: begin
                        if ((i_data_byte & MARK_DATA_MASK) == MARK_DATA) begin
                            if (i_data_byte[1:0] != MARK_NORMAL && i_cfg.simple_image
                                && i_cfg.physical_track != 7'(DIRECTORY_TRACK)) begin
                                fail      = 1'b1;
                                fail_code = ERR_DIR;
                            end else begin
                                if (i_data_byte[1:0] != MARK_NORMAL) begin
                                    n_hdr_flags = r_hdr_flags | FLAG_DIR;
                                end
                                n_data_left = DLEFT_W'(SECTOR_BYTES);
                                n_state     = ST_DATA;
                            end
                        end
                    end
                    ST_DATA: begin
                        res.event_res  = EV_DATA;
                        res.store_byte = i_data_byte;
                        res.byte_index = idx_full[7:0];
                        if (r_data_left != '0) begin
                            n_data_left = r_data_left - DLEFT_W'(1);
                        end
                        if (r_data_left <= DLEFT_W'(1)) begin
                            n_state = ST_DCRC;
                        end
                    end
                    ST_DCRC: begin
                        if (i_data_byte != CRC_BYTE && i_cfg.simple_image) begin
                            fail      = 1'b1;
                            fail_code = ERR_CRC;
                        end else begin
                            if (i_data_byte == CRC_BYTE) begin
                                if (raw_dec != '0) begin
                                    n_raw_left = raw_dec - BUDGET_W'(1);
                                end
                            end else begin
                                n_hdr_flags = r_hdr_flags | FLAG_CRC;
                            end
                            res.event_res = EV_HEADER;
                            res.id_track  = r_hdr_track;
                            res.id_sector = r_hdr_sector;
                            res.id_flags  = n_hdr_flags;
                            n_state       = ST_GAP1;
                        end
                    end
                    default: begin
                        n_state       = ST_DONE;
                        res.event_res = EV_DONE;
                    end
                endcase
                if (fail) begin
                    res.event_res  = EV_ERROR;
                    res.error_code = fail_code;
                    n_state        = ST_DONE;
                    n_raw_left     = '0;
                    n_data_left    = '0;
                end
            end
        end
        res.busy_res = (n_state != ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_DONE;
            r_raw_left   <= '0;
            r_data_left  <= '0;
            r_hdr_track  <= '0;
            r_hdr_sector <= '0;
            r_hdr_flags  <= '0;
        end else if (i_accept) begin
            r_state      <= n_state;
            r_raw_left   <= n_raw_left;
            r_data_left  <= n_data_left;
            r_hdr_track  <= n_hdr_track;
            r_hdr_sector <= n_hdr_sector;
            r_hdr_flags  <= n_hdr_flags;
        end
    end

    assign o_result = res;

    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && res.event_res == EV_ERROR |=> r_state == ST_DONE && r_raw_left == '0)
        else $error("error result did not end the format");

    a_data_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DATA |-> r_data_left != '0 && r_data_left <= DLEFT_W'(SECTOR_BYTES))
        else $error("sector byte count out of range in data phase");

    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_state != ST_DONE) == $past(res.busy_res))
        else $error("busy flag disagrees with parse state");

endmodule

`default_nettype wire

### rtl/ftfp_outq.sv
// Two-entry result queue that decouples the parser from the result channel.
`timescale 1ns / 1ps
`default_nettype none

module ftfp_outq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  ftfp_pkg::t_result    i_result,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire                  i_stall,
    output ftfp_pkg::t_result    o_result
);
    import ftfp_pkg::*;

    t_result    r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop = o_valid && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_result;
        end
    end

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_mem[r_rd];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("request taken while result queue is full");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr == r_rd) == (r_cnt == 2'd0 || r_cnt == 2'd2))
        else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire

### rtl/floppy_track_format_parser_core.sv
// Top level of the floppy write-track format stream parser.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+----------------------------------
//  in       | sink      | i_in_valid / o_in_stall | i_opcode, i_data_byte
//  out      | source    | o_out_valid/i_out_stall | o_event_res .. o_busy_res
//  cfg      | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each request is parsed in the cycle it is accepted and its result is registered
// in the result queue; one request per cycle is sustained while i_out_stall is low.
// The result side is a two-entry queue, so the input is stalled only when two
// results are waiting.
// Reset is synchronous and active low; the parser comes up idle with no format
// running and the track length set to 3125 bytes.
`timescale 1ns / 1ps
`default_nettype none

module floppy_track_format_parser_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_opcode,
    input  wire  [7:0]                       i_data_byte,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [2:0]                       o_event_res,
    output logic [7:0]                       o_store_byte,
    output logic [7:0]                       o_byte_index,
    output logic [7:0]                       o_id_track,
    output logic [7:0]                       o_id_sector,
    output logic [7:0]                       o_id_flags,
    output logic [3:0]                       o_error_code,
    output logic                             o_busy_res,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [ftfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [ftfp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ftfp_pkg::*;

    t_cfg    cfg;
    t_result parse_res;
    t_result q_res;
    logic    q_full;
    logic    accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;

    ftfp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ftfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .o_result    (parse_res)
    );

    ftfp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_result (parse_res),
        .o_full   (q_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (q_res)
    );

    assign o_event_res  = q_res.event_res;
    assign o_store_byte = q_res.store_byte;
    assign o_byte_index = q_res.byte_index;
    assign o_id_track   = q_res.id_track;
    assign o_id_sector  = q_res.id_sector;
    assign o_id_flags   = q_res.id_flags;
    assign o_error_code = q_res.error_code;
    assign o_busy_res   = q_res.busy_res;

endmodule

`default_nettype wire

### verif/tb_floppy_track_format_parser_core.sv
// Self-checking testbench for the floppy write-track format parser core.
`timescale 1ns / 1ps

module tb_floppy_track_format_parser_core;
    import ftfp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_TARGET = 1900;

    typedef enum logic [3:0] {
        PS_GAP0   = 4'd0,
        PS_GAP1   = 4'd1,
        PS_TRACK  = 4'd2,
        PS_HEAD   = 4'd3,
        PS_SECTOR = 4'd4,
        PS_SIZE   = 4'd5,
        PS_GAP2   = 4'd6,
        PS_DATA   = 4'd7,
        PS_CRC    = 4'd8,
        PS_DONE   = 4'd15
    } t_parse_state;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_opcode = 1'b0;
    logic [7:0]            in_data_byte = 8'h00;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wire        o_in_stall;
    wire        o_out_valid;
    wire [2:0]  o_event_res;
    wire [7:0]  o_store_byte;
    wire [7:0]  o_byte_index;
    wire [7:0]  o_id_track;
    wire [7:0]  o_id_sector;
    wire [7:0]  o_id_flags;
    wire [3:0]  o_error_code;
    wire        o_busy_res;
    wire        o_cfg_ready;

    t_cfg         cfg = '{7'd0, 1'b0, 1'b0, 1'b0, TRACK_LENGTH_RESET};
    t_parse_state parse_state = PS_DONE;
    logic [15:0]  raw_left = '0;
    logic [8:0]   sector_left = '0;
    logic [7:0]   hdr_track = '0;
    logic [7:0]   hdr_sector = '0;
    logic [7:0]   hdr_flags = '0;

    t_result expected_results[$];
    int      error_count = 0;
    int      item_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    bit      gapless = 1'b0;
    int      hold_req = 0;
    int      hold_left = 0;
    int      pattern_left = 0;
    int      stall_pct = 0;

    floppy_track_format_parser_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (in_opcode),
        .i_data_byte  (in_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_event_res  (o_event_res),
        .o_store_byte (o_store_byte),
        .o_byte_index (o_byte_index),
        .o_id_track   (o_id_track),
        .o_id_sector  (o_id_sector),
        .o_id_flags   (o_id_flags),
        .o_error_code (o_error_code),
        .o_busy_res   (o_busy_res),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic t_result parse_byte(input t_opcode op, input logic [7:0] b);
        t_result r;
        t_error  err;
        int      idx;
        r = '0;
        err = ERR_NONE;
        if (op == OP_START) begin
            raw_left = {2'b00, cfg.track_length};
            sector_left = '0;
            parse_state = PS_GAP0;
        end else if (parse_state != PS_DONE) begin
            if (raw_left == '0) begin
                parse_state = PS_DONE;
                sector_left = '0;
                r.event_res = EV_DONE;
            end else begin
                raw_left = raw_left - 16'd1;
                case (parse_state)
                    PS_GAP0: begin
                        if (b == MARK_INDEX) parse_state = PS_GAP1;
                        else if (b == MARK_ID) parse_state = PS_TRACK;
                    end
                    PS_GAP1: begin
                        if (b == MARK_ID) parse_state = PS_TRACK;
                    end
                    PS_TRACK: begin
                        hdr_track = b;
                        if (b != {1'b0, cfg.physical_track}) err = ERR_TRACK;
                        else parse_state = PS_HEAD;
                    end
                    PS_HEAD: begin
                        if (cfg.simple_image) begin
                            if (b != 8'h00) err = ERR_SIDED;
                            else if (cfg.double_density) err = ERR_DENSITY;
                        end else if (b != {7'b0, cfg.head_side}) begin
                            err = ERR_HEAD;
                        end
                        if (err == ERR_NONE) begin
                            hdr_flags = ((b != 8'h00) ? FLAG_SIDE : 8'h00)
                                      | (cfg.double_density ? FLAG_DENSITY : 8'h00);
                            parse_state = PS_SECTOR;
                        end
                    end
                    PS_SECTOR: begin
                        hdr_sector = b;
                        if (cfg.simple_image && b >= 8'(SIMPLE_SECTORS)) err = ERR_SECTOR;
                        else parse_state = PS_SIZE;
                    end
                    PS_SIZE: begin
                        if (b != SIZE_CODE) err = ERR_SIZE;
                        else parse_state = PS_GAP2;
                    end
                    PS_GAP2: begin
                        if ((b & MARK_DATA_MASK) == MARK_DATA) begin
                            if (b[1:0] != MARK_NORMAL) begin
                                if (cfg.simple_image
                                    && cfg.physical_track != 7'(DIRECTORY_TRACK))
                                    err = ERR_DIR;
                                else
                                    hdr_flags = hdr_flags | FLAG_DIR;
                            end
                            if (err == ERR_NONE) begin
                                sector_left = 9'(SECTOR_BYTES);
                                parse_state = PS_DATA;
                            end
                        end
                    end
                    PS_DATA: begin
                        idx = SECTOR_BYTES - int'(sector_left);
                        r.event_res = EV_DATA;
                        r.store_byte = b;
                        r.byte_index = idx[7:0];
                        if (sector_left != '0) sector_left = sector_left - 9'd1;
                        if (sector_left == '0) parse_state = PS_CRC;
                    end
                    PS_CRC: begin
                        // A good CRC mark stands for two bytes on the disk.
                        if (b == CRC_BYTE) begin
                            if (raw_left != '0) raw_left = raw_left - 16'd1;
                        end else if (cfg.simple_image) begin
                            err = ERR_CRC;
                        end else begin
                            hdr_flags = hdr_flags | FLAG_CRC;
                        end
                        if (err == ERR_NONE) begin
                            r.event_res = EV_HEADER;
                            r.id_track = hdr_track;
                            r.id_sector = hdr_sector;
                            r.id_flags = hdr_flags;
                            parse_state = PS_GAP1;
                        end
                    end
                    default: begin
                        parse_state = PS_DONE;
                        r.event_res = EV_DONE;
                    end
                endcase
            end
        end
        if (err != ERR_NONE) begin
            r.event_res = EV_ERROR;
            r.error_code = err;
            parse_state = PS_DONE;
            raw_left = '0;
            sector_left = '0;
        end
        r.busy_res = (parse_state != PS_DONE);
        return r;
    endfunction

    always @(posedge clk) begin
        if (rst_n && in_valid && !o_in_stall) begin
            item_count++;
            expected_results.push_back(parse_byte(t_opcode'(in_opcode), in_data_byte));
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        t_result want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("event_res", want.event_res, o_event_res);
                check_field("store_byte", want.store_byte, o_store_byte);
                check_field("byte_index", want.byte_index, o_byte_index);
                check_field("id_track", want.id_track, o_id_track);
                check_field("id_sector", want.id_sector, o_id_sector);
                check_field("id_flags", want.id_flags, o_id_flags);
                check_field("error_code", want.error_code, o_error_code);
                check_field("busy_res", want.busy_res, o_busy_res);
            end
        end
    end

    always @(posedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int next_gap();
        if (gapless) return 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(1, 40);
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    endfunction

    task automatic send_item(input t_opcode op, input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        in_opcode <= op;
        in_data_byte <= b;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        gap = next_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        if (in_valid) in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        case (idx)
            CFG_PHYS_TRACK:   cfg.physical_track = value[6:0];
            CFG_HEAD_SIDE:    cfg.head_side = value[0];
            CFG_DOUBLE_DENS:  cfg.double_density = value[0];
            CFG_SIMPLE_IMAGE: cfg.simple_image = value[0];
            CFG_TRACK_LENGTH: cfg.track_length = value[BUDGET_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Unused upper bits of the narrow registers carry random values.
    task automatic configure(input logic [6:0] track, input logic head, input logic dd,
                             input logic simple, input logic [13:0] length);
        logic [13:0] junk;
        wait_idle();
        junk = 14'($urandom());
        write_register(CFG_PHYS_TRACK, {junk[13:7], track});
        junk = 14'($urandom());
        write_register(CFG_HEAD_SIDE, {junk[13:1], head});
        junk = 14'($urandom());
        write_register(CFG_DOUBLE_DENS, {junk[13:1], dd});
        junk = 14'($urandom());
        write_register(CFG_SIMPLE_IMAGE, {junk[13:1], simple});
        write_register(CFG_TRACK_LENGTH, length);
    endtask

    function automatic logic [7:0] gap_byte();
        logic [7:0] b;
        b = 8'($urandom());
        if (b == MARK_ID || b == MARK_INDEX) b[4] = 1'b0;
        return b;
    endfunction

    function automatic logic [7:0] maybe_corrupt(input logic [7:0] b, input bit clean);
        if (!clean && $urandom_range(0, 5) == 0) return 8'($urandom());
        return b;
    endfunction

    task automatic send_sector_data(input logic [7:0] seed);
        int i;
        for (i = 0; i < SECTOR_BYTES; i++) send_item(OP_BYTE, i[7:0] ^ seed);
    endtask

    task automatic send_track(input int sectors, input bit clean);
        logic [7:0] b;
        int         s;
        send_item(OP_START, 8'($urandom()));
        repeat ($urandom_range(0, 6)) send_item(OP_BYTE, gap_byte());
        if ($urandom_range(0, 1)) send_item(OP_BYTE, MARK_INDEX);
        for (s = 0; s < sectors; s++) begin
            repeat ($urandom_range(0, 3)) send_item(OP_BYTE, gap_byte());
            send_item(OP_BYTE, MARK_ID);
            send_item(OP_BYTE, maybe_corrupt({1'b0, cfg.physical_track}, clean));
            b = cfg.simple_image ? 8'h00 : {7'b0, cfg.head_side};
            send_item(OP_BYTE, maybe_corrupt(b, clean));
            if (cfg.simple_image) b = 8'($urandom_range(0, SIMPLE_SECTORS - 1));
            else b = 8'($urandom());
            send_item(OP_BYTE, maybe_corrupt(b, clean));
            send_item(OP_BYTE, maybe_corrupt(SIZE_CODE, clean));
            repeat ($urandom_range(0, 3)) begin
                b = 8'($urandom());
                if ((b & MARK_DATA_MASK) == MARK_DATA) b[4] = 1'b0;
                send_item(OP_BYTE, b);
            end
            if (cfg.simple_image && cfg.physical_track != 7'(DIRECTORY_TRACK) && clean)
                b = MARK_DATA | {6'd0, MARK_NORMAL};
            else
                b = MARK_DATA | 8'($urandom_range(0, 3));
            send_item(OP_BYTE, b);
            repeat (SECTOR_BYTES) send_item(OP_BYTE, 8'($urandom()));
            b = CRC_BYTE;
            if (!clean && $urandom_range(0, 3) == 0) b = 8'($urandom());
            send_item(OP_BYTE, b);
        end
    endtask

    task automatic test_stream_errors();
        configure(7'd0, 1'b0, 1'b0, 1'b0, TRACK_LENGTH_RESET);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_START, 8'hA5);
        send_item(OP_BYTE, 8'h4E);
        send_item(OP_BYTE, MARK_INDEX);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'h05);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_START, 8'hFF);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h02);
    endtask

    task automatic test_simple_image_checks();
        configure(7'd95, 1'b1, 1'b1, 1'b1, 14'd16383);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'd95);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'd95);
        send_item(OP_BYTE, 8'h00);
        configure(7'd95, 1'b1, 1'b0, 1'b1, 14'd16383);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'd95);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'(SIMPLE_SECTORS));
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'd95);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'(SIMPLE_SECTORS - 1));
        send_item(OP_BYTE, SIZE_CODE);
        send_item(OP_BYTE, MARK_DATA);
    endtask

    task automatic test_budget_limits();
        configure(7'd0, 1'b0, 1'b0, 1'b0, 14'd0);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, MARK_ID);
        configure(7'd0, 1'b0, 1'b0, 1'b0, 14'd1);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'h00);
        configure(7'd0, 1'b0, 1'b0, 1'b0, 14'd3);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_INDEX);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00);
    endtask

    task automatic test_sector_paths();
        // The budget runs out exactly on the good CRC mark.
        configure(7'(DIRECTORY_TRACK), 1'b0, 1'b0, 1'b1, 14'd263);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'(DIRECTORY_TRACK));
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'(SIMPLE_SECTORS - 1));
        send_item(OP_BYTE, SIZE_CODE);
        send_item(OP_BYTE, MARK_DATA);
        send_sector_data(8'h5A);
        send_item(OP_BYTE, CRC_BYTE);
        send_item(OP_BYTE, 8'h4E);
        configure(7'(DIRECTORY_TRACK), 1'b0, 1'b0, 1'b1, TRACK_LENGTH_RESET);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'(DIRECTORY_TRACK));
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, SIZE_CODE);
        send_item(OP_BYTE, MARK_DATA | {6'd0, MARK_NORMAL});
        send_sector_data(8'hC3);
        send_item(OP_BYTE, 8'h00);
        configure(7'(DIRECTORY_TRACK), 1'b1, 1'b1, 1'b0, TRACK_LENGTH_RESET);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'(DIRECTORY_TRACK));
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, SIZE_CODE);
        send_item(OP_BYTE, MARK_DATA | 8'h02);
        send_sector_data(8'h00);
        send_item(OP_BYTE, 8'h12);
        send_item(OP_BYTE, MARK_INDEX);
        send_item(OP_BYTE, MARK_ID);
        send_item(OP_BYTE, 8'(DIRECTORY_TRACK));
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, SIZE_CODE);
        send_item(OP_BYTE, MARK_DATA | {6'd0, MARK_NORMAL});
        send_sector_data(8'hFF);
        send_item(OP_BYTE, CRC_BYTE);
    endtask

    task automatic test_backpressure();
        configure(7'd3, 1'b0, 1'b0, 1'b0, TRACK_LENGTH_RESET);
        gapless = 1'b1;
        hold_req = 400;
        send_track(1, 1'b1);
        gapless = 1'b0;
    endtask

    task automatic test_random_formats();
        logic [6:0]  track;
        logic [13:0] length;
        while (item_count < ITEM_TARGET) begin
            case ($urandom_range(0, 4))
                0: track = 7'd0;
                1: track = 7'(DIRECTORY_TRACK);
                2: track = 7'd95;
                default: track = 7'($urandom());
            endcase
            case ($urandom_range(0, 6))
                0: length = 14'($urandom_range(0, 4));
                1: length = 14'($urandom_range(258, 275));
                2: length = TRACK_LENGTH_RESET;
                3: length = 14'd16383;
                4, 5: length = 14'($urandom_range(280, 1200));
                default: length = 14'($urandom());
            endcase
            configure(track, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                      1'($urandom_range(0, 1)), length);
            repeat ($urandom_range(1, 3)) begin
                send_track(($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, 1),
                           $urandom_range(0, 3) != 0);
                repeat ($urandom_range(0, 8))
                    send_item(($urandom_range(0, 15) == 0) ? OP_START : OP_BYTE,
                              8'($urandom()));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stream_errors();
        test_simple_image_checks();
        test_budget_limits();
        test_sector_paths();
        test_backpressure();
        test_random_formats();
        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### floppy_track_format_parser_core.f
rtl/ftfp_pkg.sv
rtl/ftfp_cfg.sv
rtl/ftfp_parser.sv
rtl/ftfp_outq.sv
rtl/floppy_track_format_parser_core.sv
verif/tb_floppy_track_format_parser_core.sv
